@@ rtl/etfr_pkg.sv @@
// Shared types, constants and the temperature table of the telemetry frame receiver.
package etfr_pkg;

  localparam int unsigned FrameLen    = 24;
  localparam int unsigned CrcSpan     = 22;
  localparam int unsigned TempBase    = 33;
  localparam int unsigned TempEntries = 209;

  localparam logic [7:0]  SyncReset      = 8'h9B;
  localparam logic [15:0] HuntLimitReset = 16'd1000;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl    = 16'hA001;
  localparam logic [20:0] ThrottleScale  = 21'd25;

  // Configuration register indexes
  localparam logic [7:0] CfgSyncValue = 8'd0;
  localparam logic [7:0] CfgHuntLimit = 8'd1;

  typedef enum logic [1:0] {
    StatusGood        = 2'd0,
    StatusCrcBad      = 2'd1,
    StatusSyncTimeout = 2'd2
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [20:0]        in_throttle_pct_q8;
    logic [20:0]        out_throttle_pct_q8;
    logic [15:0]        speed_rpm;
    logic [15:0]        supply_decivolts;
    logic signed [15:0] supply_current_q6;
    logic signed [15:0] phase_current_q6;
    logic [7:0]         fet_temp_c;
    logic [7:0]         capacitor_temp_c;
    logic [15:0]        fault_bits;
  } result_t;

  // Degrees for raw temperature codes TempBase .. TempBase + TempEntries - 1
  localparam logic [7:0] TempTable [TempEntries] = '{
    8'd129, 8'd128, 8'd127, 8'd126, 8'd125, 8'd124, 8'd122, 8'd121, 8'd120, 8'd119,
    8'd118, 8'd117, 8'd116, 8'd115, 8'd114, 8'd113, 8'd113, 8'd112, 8'd110, 8'd110,
    8'd109, 8'd107, 8'd107, 8'd106, 8'd106, 8'd105, 8'd104, 8'd104, 8'd103, 8'd101,
    8'd101, 8'd100, 8'd99,  8'd98,  8'd98,  8'd97,  8'd96,  8'd96,  8'd96,  8'd95,
    8'd94,  8'd93,  8'd93,  8'd92,  8'd91,  8'd91,  8'd90,  8'd90,  8'd89,  8'd88,
    8'd88,  8'd87,  8'd86,  8'd86,  8'd86,  8'd85,  8'd85,  8'd84,  8'd83,  8'd83,
    8'd82,  8'd82,  8'd81,  8'd81,  8'd80,  8'd80,  8'd79,  8'd79,  8'd78,  8'd78,
    8'd77,  8'd77,  8'd76,  8'd75,  8'd75,  8'd75,  8'd74,  8'd74,  8'd73,  8'd73,
    8'd72,  8'd72,  8'd71,  8'd71,  8'd70,  8'd70,  8'd69,  8'd69,  8'd68,  8'd68,
    8'd67,  8'd67,  8'd66,  8'd66,  8'd66,  8'd65,  8'd65,  8'd64,  8'd64,  8'd63,
    8'd63,  8'd62,  8'd62,  8'd61,  8'd61,  8'd61,  8'd60,  8'd60,  8'd59,  8'd59,
    8'd58,  8'd58,  8'd58,  8'd57,  8'd57,  8'd56,  8'd56,  8'd55,  8'd55,  8'd54,
    8'd54,  8'd53,  8'd53,  8'd53,  8'd52,  8'd52,  8'd51,  8'd51,  8'd50,  8'd50,
    8'd50,  8'd49,  8'd49,  8'd48,  8'd48,  8'd47,  8'd47,  8'd46,  8'd46,  8'd45,
    8'd45,  8'd44,  8'd44,  8'd44,  8'd43,  8'd43,  8'd42,  8'd42,  8'd41,  8'd41,
    8'd40,  8'd40,  8'd39,  8'd39,  8'd38,  8'd38,  8'd37,  8'd37,  8'd36,  8'd36,
    8'd35,  8'd35,  8'd34,  8'd34,  8'd33,  8'd33,  8'd32,  8'd32,  8'd31,  8'd30,
    8'd30,  8'd29,  8'd29,  8'd28,  8'd28,  8'd27,  8'd26,  8'd26,  8'd25,  8'd25,
    8'd24,  8'd23,  8'd23,  8'd22,  8'd21,  8'd21,  8'd20,  8'd19,  8'd19,  8'd18,
    8'd17,  8'd16,  8'd16,  8'd15,  8'd14,  8'd13,  8'd12,  8'd11,  8'd10,  8'd9,
    8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd2,   8'd1,   8'd0
  };

  // Map a raw temperature byte to degrees, clamping to the table ends
  function automatic logic [7:0] temp_of(input logic [7:0] raw);
    logic [7:0] idx;
    if (raw < 8'(TempBase)) begin
      idx = 8'd0;
    end else if (raw > 8'(TempBase + TempEntries - 1)) begin
      idx = 8'(TempEntries - 1);
    end else begin
      idx = raw - 8'(TempBase);
    end
    return TempTable[idx];
  endfunction

endpackage

@@ rtl/etfr_if.sv @@
// Valid/ready channel interfaces of the telemetry frame receiver.
interface etfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface etfr_res_if;
  logic              valid;
  logic              ready;
  etfr_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface etfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/esc_telemetry_frame_receiver.sv @@
// Telemetry frame receiver: sync hunt, CRC-16/MODBUS check and field decode.
//
// rx_i carries one received serial byte per transaction. While hunting, a byte
// equal to sync_value starts a 24-byte frame; other bytes are counted, and when
// the count reaches hunt_limit a sync-timeout result is sent and the count restarts.
// Bytes 0..21 feed the CRC; bytes 22 (low) and 23 (high) hold the expected CRC.
// The 24th byte yields one result on res_o: status and the decoded fields when
// the CRC matches, status alone (other fields zero) on mismatch or timeout.
// cfg_i writes sync_value (index 0) and hunt_limit (index 1); it is always ready.
// Timing: one byte per cycle is accepted while rx_i.ready is high. Each result is
// registered in the output register, or in a one-entry skid stage if the output
// register is full and not taken; so rx_i keeps taking bytes while a result waits.
// rx_i.ready drops only when both are full and returns once res_o takes a result.
// Reset: hunting, skip count zero, registers at sync 0x9B and limit 1000, no
// result pending. Frame storage holds no reset value; each byte is written
// before it is read.
module esc_telemetry_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  etfr_rx_if.sink    rx_i,
  etfr_cfg_if.sink   cfg_i,
  etfr_res_if.source res_o
);
  import etfr_pkg::*;

  logic [7:0]  sync_q;
  logic [15:0] limit_q;
  logic        collecting_q;
  logic [4:0]  pos_q;
  logic [15:0] skip_q;
  logic [15:0] crc_q;
  logic [7:0]  frame_q [6:22];

  logic        out_v_q, skid_v_q;
  result_t     out_q, skid_q;

  logic        rx_take, res_take;
  logic        new_res;
  result_t     new_data;
  logic [15:0] crc_next;
  logic [15:0] skip_inc;
  logic        last_byte;

  // Bytewise reflected CRC-16 update
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

  assign rx_i.ready  = !skid_v_q;
  assign cfg_i.ready = 1'b1;
  assign rx_take     = rx_i.valid && rx_i.ready;
  assign res_take    = out_v_q && res_o.ready;

  assign crc_next  = crc_feed(collecting_q ? crc_q : CrcInit, rx_i.rx_byte);
  assign skip_inc  = skip_q + 16'd1;
  assign last_byte = collecting_q && (pos_q == 5'(FrameLen - 1));

  // Decode the result caused by the byte on rx_i
  always_comb begin
    new_res  = 1'b0;
    new_data = '0;
    if (!collecting_q) begin
      if ((rx_i.rx_byte != sync_q) && (skip_inc >= limit_q)) begin
        new_res         = 1'b1;
        new_data.status = StatusSyncTimeout;
      end
    end else if (last_byte) begin
      new_res = 1'b1;
      if (crc_q != {rx_i.rx_byte, frame_q[22]}) begin
        new_data.status = StatusCrcBad;
      end else begin
        new_data.status              = StatusGood;
        new_data.in_throttle_pct_q8  = {5'd0, frame_q[6], frame_q[7]} * ThrottleScale;
        new_data.out_throttle_pct_q8 = {5'd0, frame_q[8], frame_q[9]} * ThrottleScale;
        new_data.speed_rpm           = {frame_q[10], frame_q[11]};
        new_data.supply_decivolts    = {frame_q[12], frame_q[13]};
        new_data.supply_current_q6   = {frame_q[14], frame_q[15]};
        new_data.phase_current_q6    = {frame_q[16], frame_q[17]};
        new_data.fet_temp_c          = temp_of(frame_q[18]);
        new_data.capacitor_temp_c    = temp_of(frame_q[19]);
        new_data.fault_bits          = {frame_q[20], frame_q[21]};
      end
    end
  end

  // Apply configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= SyncReset;
      limit_q <= HuntLimitReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgSyncValue: sync_q  <= cfg_i.data[7:0];
        CfgHuntLimit: limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Advance the hunt / collect state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      pos_q        <= '0;
      skip_q       <= '0;
      crc_q        <= CrcInit;
    end else if (rx_take) begin
      if (!collecting_q) begin
        if (rx_i.rx_byte == sync_q) begin
          collecting_q <= 1'b1;
          pos_q        <= 5'd1;
          skip_q       <= '0;
          crc_q        <= crc_next;
        end else begin
          skip_q <= new_res ? 16'd0 : skip_inc;
        end
      end else if (last_byte) begin
        collecting_q <= 1'b0;
        pos_q        <= '0;
        skip_q       <= '0;
        crc_q        <= CrcInit;
      end else begin
        pos_q <= pos_q + 5'd1;
        if (pos_q < 5'(CrcSpan)) begin
          crc_q <= crc_next;
        end
      end
    end
  end

  // Capture the frame bytes that the decode reads
  always_ff @(posedge clk_i) begin
    if (rx_take && collecting_q && (pos_q >= 5'd6) && (pos_q <= 5'd22)) begin
      frame_q[pos_q] <= rx_i.rx_byte;
    end
  end

  // Output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (res_take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || res_take) begin
      out_v_q <= rx_take && new_res;
    end else if (rx_take && new_res) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (res_take) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || res_take) begin
      out_q <= new_data;
    end else begin
      skid_q <= new_data;
    end
  end

  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  // Skid stage holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full with output register empty");

  // Draining a full skid stage keeps a result on the output
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && res_take) |=> (out_v_q && !skid_v_q))
    else $error("skid stage drain lost a result");

  // Frame position stays inside the frame and is zero while hunting
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (collecting_q && (pos_q <= 5'(FrameLen - 1)) && (pos_q != 5'd0)) ||
    (!collecting_q && (pos_q == 5'd0)))
    else $error("frame position out of range");

endmodule
